// ===== rtl/bll_pkg.sv =====
// Shared types and constants for the binary-lifting lowest-common-ancestor block.
// Used by bll_front, bll_back and binary_lifting_lca; depends on nothing else.
`timescale 1ns / 1ps

package bll_pkg;

  localparam int unsigned NODE_W          = 10;
  localparam int unsigned CLOCK_W         = 12;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned IN_DATA_W       = 24;
  localparam int unsigned OUT_DATA_W      = 16;
  localparam int unsigned MAX_NODES_DEF   = 1024;
  localparam int unsigned LIFT_LEVELS_DEF = 11;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_QUERY = 2'd2
  } bll_op_t;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    bll_op_t             op;
    logic [NODE_W-1:0]   node;
    logic [NODE_W-1:0]   other;
    logic [CLOCK_W-1:0]  stamp;
  } bll_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_TEST,
    ST_LIFT
  } bll_state_t;

endpackage

// ===== rtl/bll_front.sv =====
// Front end: accepts requests, reduces node numbers, stamps tour events and queues them.
// Depends on bll_pkg.
`timescale 1ns / 1ps

module bll_front #(
  parameter int unsigned MAX_NODES = bll_pkg::MAX_NODES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bll_pkg::OP_W-1:0]             in_op,
  input  logic [bll_pkg::NODE_W-1:0]           in_node,
  input  logic [bll_pkg::NODE_W-1:0]           in_other,
  output logic                                 cmd_valid,
  output bll_pkg::bll_cmd_t                    cmd,
  input  logic                                 cmd_pop
);
  import bll_pkg::*;

  localparam int unsigned NODE_SPAN = 1 << NODE_W;

  bll_cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]       count_r, count_nxt;
  logic [CLOCK_W-1:0]    clock_r, clock_nxt;
  logic                  accept;
  logic                  push;
  logic                  stamped;
  bll_cmd_t              new_cmd;

  // Reduce a node number modulo MAX_NODES by conditional subtraction of
  // shifted multiples; only multiples that fit in the field take part.
  function automatic logic [NODE_W-1:0] reduce_node(input logic [NODE_W-1:0] x);
    logic [NODE_W-1:0] r;
    r = x;
    for (int k = NODE_W - 1; k >= 0; k--) begin
      if ((MAX_NODES << k) < NODE_SPAN) begin
        if (32'(r) >= (MAX_NODES << k)) begin
          r = r - NODE_W'(MAX_NODES << k);
        end
      end
    end
    return r;
  endfunction

  assign in_ready  = (count_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign accept    = in_valid && in_ready;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    new_cmd.node  = reduce_node(in_node);
    new_cmd.other = reduce_node(in_other);
    new_cmd.stamp = clock_r + 1'b1;
    new_cmd.op    = OP_QUERY;
    push          = 1'b0;
    stamped       = 1'b0;
    case (in_op)
      OP_ENTER: begin
        new_cmd.op = OP_ENTER;
        push       = accept;
        stamped    = accept;
      end
      OP_EXIT: begin
        new_cmd.op = OP_EXIT;
        push       = accept;
        stamped    = accept;
      end
      OP_QUERY: begin
        new_cmd.op = OP_QUERY;
        push       = accept;
      end
      default: begin
        // The unused operation code is taken and dropped.
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(cmd_pop);
    clock_nxt  = stamped ? new_cmd.stamp : clock_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      clock_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      clock_r  <= clock_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== rtl/bll_back.sv =====
// Back end: time-stamp and jump-table memories with the enter/exit/query sequencer.
// Depends on bll_pkg.
`timescale 1ns / 1ps

module bll_back #(
  parameter int unsigned MAX_NODES   = bll_pkg::MAX_NODES_DEF,
  parameter int unsigned LIFT_LEVELS = bll_pkg::LIFT_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  bll_pkg::bll_cmd_t           cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bll_pkg::NODE_W-1:0]  out_ancestor
);
  import bll_pkg::*;

  localparam int unsigned NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned JW    = $clog2(MAX_NODES * LIFT_LEVELS);
  localparam int unsigned LW    = $clog2(LIFT_LEVELS);
  localparam int unsigned JDEPTH = MAX_NODES * LIFT_LEVELS;

  // Memories.
  logic [CLOCK_W-1:0] entry_mem [MAX_NODES];
  logic [CLOCK_W-1:0] exit_mem  [MAX_NODES];
  logic [NODE_W-1:0]  jump_mem  [JDEPTH];

  // Memory controls and registered read data.
  logic               tw_entry, tw_exit;
  logic [NW-1:0]      tw_addr;
  logic [CLOCK_W-1:0] tw_data;
  logic [NW-1:0]      ta_addr, tb_addr;
  logic [CLOCK_W-1:0] ea_q, eb_q, xa_q, xb_q;
  logic               jw_en;
  logic [JW-1:0]      jw_addr, jra_addr, jrb_addr;
  logic [NODE_W-1:0]  jw_data;
  logic [NODE_W-1:0]  ja_q, jb_q;

  // Sequencer state.
  bll_state_t         st_r, st_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic [NODE_W-1:0]  bnode_r, bnode_nxt;
  logic [NODE_W-1:0]  cand_r, cand_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]  out_anc_r, out_anc_nxt;

  logic               a_covers_b, b_covers_a;
  logic [NODE_W-1:0]  a_new, up_next;
  logic [LW-1:0]      lvl_issue;

  function automatic logic [JW-1:0] jaddr(input logic [NODE_W-1:0] v,
                                          input logic [LW-1:0] lvl);
    return JW'(JW'(v) * JW'(LIFT_LEVELS)) + JW'(lvl);
  endfunction

  assign cmd_pop      = (st_r == ST_IDLE) && cmd_valid &&
                        ((cmd.op != OP_QUERY) || !out_valid_r);
  assign out_valid    = out_valid_r;
  assign out_ancestor = out_anc_r;

  // Port A carries the node under test, port B the second query node.
  assign a_covers_b = (ea_q <= eb_q) && (xa_q >= xb_q);
  assign b_covers_a = (eb_q <= ea_q) && (xb_q >= xa_q);
  assign a_new      = a_covers_b ? node_r : cand_r;
  assign up_next    = a_covers_b ? ja_q : jb_q;
  assign lvl_issue  = (lvl_r > LW'(1)) ? lvl_r - LW'(2) : '0;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          case (cmd.op)
            OP_ENTER: st_nxt = ST_FILL;
            OP_QUERY: st_nxt = ST_TEST;
            default:  st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (lvl_r == LW'(LIFT_LEVELS - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_TEST: begin
        st_nxt = (a_covers_b || b_covers_a) ? ST_IDLE : ST_LIFT;
      end
      ST_LIFT: begin
        if (lvl_r == '0) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    tw_entry      = 1'b0;
    tw_exit       = 1'b0;
    tw_addr       = NW'(cmd.node);
    tw_data       = cmd.stamp;
    ta_addr       = NW'(cand_r);
    tb_addr       = NW'(bnode_r);
    jw_en         = 1'b0;
    jw_addr       = jaddr(node_r, lvl_r);
    jw_data       = ja_q;
    jra_addr      = jaddr(ja_q, lvl_r);
    jrb_addr      = jaddr(cand_r, lvl_r);
    lvl_nxt       = lvl_r;
    node_nxt      = node_r;
    bnode_nxt     = bnode_r;
    cand_nxt      = cand_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_anc_nxt   = out_anc_r;
    case (st_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          node_nxt  = cmd.node;
          bnode_nxt = cmd.other;
          case (cmd.op)
            OP_ENTER: begin
              // Level 0 holds the parent; fetch the parent's level 0 next.
              tw_entry = 1'b1;
              jw_en    = 1'b1;
              jw_addr  = jaddr(cmd.node, '0);
              jw_data  = cmd.other;
              jra_addr = jaddr(cmd.other, '0);
              lvl_nxt  = LW'(1);
            end
            OP_EXIT: begin
              tw_exit = 1'b1;
            end
            default: begin
              ta_addr  = NW'(cmd.node);
              tb_addr  = NW'(cmd.other);
              jra_addr = jaddr(cmd.node, LW'(LIFT_LEVELS - 1));
            end
          endcase
        end
      end
      ST_FILL: begin
        // ja_q is the level lvl-1 ancestor of the level lvl-1 ancestor.
        jw_en    = 1'b1;
        jra_addr = jaddr(ja_q, lvl_r);
        if (lvl_r != LW'(LIFT_LEVELS - 1)) begin
          lvl_nxt = lvl_r + LW'(1);
        end
      end
      ST_TEST: begin
        if (a_covers_b) begin
          out_valid_nxt = 1'b1;
          out_anc_nxt   = node_r;
        end else if (b_covers_a) begin
          out_valid_nxt = 1'b1;
          out_anc_nxt   = bnode_r;
        end else begin
          cand_nxt = ja_q;
          lvl_nxt  = LW'(LIFT_LEVELS - 1);
          ta_addr  = NW'(ja_q);
          jra_addr = jaddr(node_r, LW'(LIFT_LEVELS - 2));
          jrb_addr = jaddr(ja_q, LW'(LIFT_LEVELS - 2));
        end
      end
      ST_LIFT: begin
        // The candidate replaces the current node when it is not an ancestor
        // of the second node; both next candidates were fetched in advance.
        if (lvl_r == '0) begin
          out_valid_nxt = 1'b1;
          out_anc_nxt   = up_next;
        end else begin
          node_nxt = a_new;
          cand_nxt = up_next;
          lvl_nxt  = lvl_r - LW'(1);
          ta_addr  = NW'(up_next);
          jra_addr = jaddr(a_new, lvl_issue);
          jrb_addr = jaddr(up_next, lvl_issue);
        end
      end
      default: begin
        lvl_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r     <= lvl_nxt;
    node_r    <= node_nxt;
    bnode_r   <= bnode_nxt;
    cand_r    <= cand_nxt;
    out_anc_r <= out_anc_nxt;
  end

  always_ff @(posedge clk) begin
    if (tw_entry) begin
      entry_mem[tw_addr] <= tw_data;
    end
    ea_q <= entry_mem[ta_addr];
    eb_q <= entry_mem[tb_addr];
  end

  always_ff @(posedge clk) begin
    if (tw_exit) begin
      exit_mem[tw_addr] <= tw_data;
    end
    xa_q <= exit_mem[ta_addr];
    xb_q <= exit_mem[tb_addr];
  end

  // Port A returns the entry being written in the same cycle, which the
  // fill needs when a node's ancestor chain reaches the root.
  always_ff @(posedge clk) begin
    if (jw_en) begin
      jump_mem[jw_addr] <= jw_data;
    end
    ja_q <= (jw_en && (jw_addr == jra_addr)) ? jw_data : jump_mem[jra_addr];
    jb_q <= jump_mem[jrb_addr];
  end

endmodule

// ===== rtl/binary_lifting_lca.sv =====
// Binary-lifting LCA. A request passes through the request queue to the back-end sequencer, where
// an exit writes its stamp, an enter writes its stamp and fills the jump table (one dependent
// jump-table read per level), and a query tests whether one node covers the other and lifts
// through the levels only when neither does, its result registered at out_tdata. The sequencer
// takes one request at a time and takes no new request until it has finished the last.
// Reset (synchronous, rst_n low) clears the queue, tour clock and sequencer; the memories
// are not cleared.
`timescale 1ns / 1ps

module binary_lifting_lca #(
  parameter int unsigned MAX_NODES   = bll_pkg::MAX_NODES_DEF,
  parameter int unsigned LIFT_LEVELS = bll_pkg::LIFT_LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bll_pkg::IN_DATA_W-1:0]     in_tdata,   // node [9:0], other [19:10], zero [23:20]
  input  logic [bll_pkg::OP_W-1:0]          in_tuser,   // operation [1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bll_pkg::OUT_DATA_W-1:0]    out_tdata   // ancestor [9:0], zero [15:10]
);
  import bll_pkg::*;

  // The front end decodes each request, reduces both node numbers modulo
  // MAX_NODES and gives enter and exit requests their tour stamp, so the
  // stamps follow arrival order. Requests wait in a queue of QUEUE_DEPTH entries, which keeps
  // in_tready high while the back end is busy or a result waits, until the queue is full.
  logic              cmd_valid;
  logic              cmd_pop;
  bll_cmd_t          cmd;
  logic [NODE_W-1:0] ancestor;

  bll_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_node   (in_tdata[NODE_W-1:0]),
    .in_other  (in_tdata[2*NODE_W-1:NODE_W]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // The back end runs one request at a time. A query starts only when the
  // result register is free, so a finished answer never has to be held
  // inside the lift sequence.
  bll_back #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_ancestor (ancestor)
  );

  assign out_tdata = {(OUT_DATA_W - NODE_W)'(0), ancestor};

endmodule
